>>> hdl/grid_ray_vertical_march_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertical-boundary ray march block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_VERTICAL_MARCH_ASSERT_SVH
`define GRID_RAY_VERTICAL_MARCH_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define GRVM_ASSERT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grvm assertion failed");

// Next-cycle implication check.
`define GRVM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grvm assertion failed");

`else

`define GRVM_ASSERT(name, clk, rst_n, ante, cons)
`define GRVM_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/grvm_pkg.sv
// ----------------------------------------------------------------------------
// grvm_pkg
// Shared constants and types of the vertical-boundary ray march block.
// ----------------------------------------------------------------------------
package grvm_pkg;

	localparam int MAP_DIM    = 64;
	localparam int ANGLE_BITS = 12;
	localparam int MAP_AW     = $clog2(MAP_DIM);
	localparam int DIM_W      = $clog2(MAP_DIM + 1);
	localparam int COL_W      = 10;
	localparam int QW         = 19;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CFG_IW     = 1;
	localparam int CFG_DW     = 7;

	localparam logic [CFG_IW-1:0] REG_MAP_ROWS = 1'd0;
	localparam logic [CFG_IW-1:0] REG_MAP_COLS = 1'd1;

	localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

	// One classified item as it waits between front and back.
	typedef struct packed {
		logic                    is_write;
		logic                    in_grid;
		logic [MAP_AW-1:0]       wr_row;
		logic [MAP_AW-1:0]       wr_col;
		logic                    wr_open;
		logic                    cos_zero;
		logic                    right;
		logic                    down;
		logic [16:0]             ca;
		logic [16:0]             sa;
		logic [8:0]              x0;
		logic signed [COL_W-1:0] col0;
		logic [13:0]             pos_y;
	} op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic pop;
		logic pop_cast;
		logic busy;
		logic res_load;
	} back_stat_t;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} map_cfg_t;

endpackage

>>> hdl/grvm_ifs.sv
// ----------------------------------------------------------------------------
// grvm channel interfaces
// Command, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface grvm_cmd_if;
	import grvm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [5:0]            cell_row;
	logic [5:0]            cell_col;
	logic                  cell_open;
	logic [13:0]           pos_x;
	logic [13:0]           pos_y;
	logic [ANGLE_BITS-1:0] angle;

	modport source (output valid, kind, cell_row, cell_col, cell_open, pos_x, pos_y, angle,
		input ready);
	modport sink (input valid, kind, cell_row, cell_col, cell_open, pos_x, pos_y, angle,
		output ready);
endinterface

interface grvm_result_if;
	logic        valid;
	logic        ready;
	logic        hit_valid;
	logic [23:0] distance;

	modport source (output valid, hit_valid, distance, input ready);
	modport sink (input valid, hit_valid, distance, output ready);
endinterface

interface grvm_cfg_if;
	import grvm_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/grvm_front.sv
// ----------------------------------------------------------------------------
// grvm_front
// Accepts commands, looks up sine and cosine and classifies each item.
// ----------------------------------------------------------------------------
module grvm_front (
	grvm_cmd_if.sink          cmd,
	input  grvm_pkg::fifo_stat_t fifo_stat,
	output logic              push,
	output grvm_pkg::op_t     op
);
	import grvm_pkg::*;

	localparam int QTW = ANGLE_BITS - 1;

	localparam logic [16:0] SINE_TAB [17] = '{
		17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893, 17'd36410,
		17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547,
		17'd62714, 17'd64277, 17'd65220, 17'd65536
	};

	// Sine of a quarter-turn offset, Q1.16, linear interpolation of the table.
	function automatic logic [16:0] sine_quarter(input logic [QTW-1:0] t);
		logic [16:0] u;
		logic [4:0]  i;
		logic [11:0] f;
		logic [16:0] diff;
		logic [29:0] prod;
		u = 17'({t, {(18 - ANGLE_BITS){1'b0}}});
		i = u[16:12];
		f = u[11:0];
		if (i >= 5'd16) begin
			return SINE_TAB[16];
		end
		diff = SINE_TAB[i + 5'd1] - SINE_TAB[i];
		prod = 30'(diff) * 30'(f);
		return SINE_TAB[i] + 17'(prod >> 12);
	endfunction

	logic [1:0]     quad;
	logic [QTW-1:0] r_off;
	logic [QTW-1:0] r_comp;
	logic [16:0]    sin_r;
	logic [16:0]    sin_c;

	assign quad   = cmd.angle[ANGLE_BITS-1 -: 2];
	assign r_off  = QTW'(cmd.angle[ANGLE_BITS-3:0]);
	assign r_comp = {1'b1, {(QTW - 1){1'b0}}} - r_off;
	assign sin_r  = sine_quarter(r_off);
	assign sin_c  = sine_quarter(r_comp);

	assign cmd.ready = !fifo_stat.full;
	assign push      = cmd.valid && !fifo_stat.full;

	always_comb begin
		op          = '0;
		op.is_write = !cmd.kind;
		op.in_grid  = (int'(cmd.cell_row) < MAP_DIM) && (int'(cmd.cell_col) < MAP_DIM);
		op.wr_row   = MAP_AW'(cmd.cell_row);
		op.wr_col   = MAP_AW'(cmd.cell_col);
		op.wr_open  = cmd.cell_open;
		op.cos_zero = quad[0] && (r_off == '0);
		op.ca       = quad[0] ? sin_r : sin_c;
		op.sa       = quad[0] ? sin_c : sin_r;
		op.right    = (quad == 2'd0) || (quad == 2'd3);
		op.down     = quad[1];
		op.pos_y    = cmd.pos_y;
		if (op.right) begin
			op.col0 = $signed(COL_W'(cmd.pos_x[13:8])) + COL_W'(1);
			op.x0   = 9'd256 - 9'(cmd.pos_x[7:0]);
		end else begin
			op.col0 = $signed(COL_W'(cmd.pos_x[13:8])) - COL_W'(1);
			op.x0   = 9'(cmd.pos_x[7:0]);
		end
	end

endmodule

>>> hdl/grvm_fifo.sv
// ----------------------------------------------------------------------------
// grvm_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module grvm_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  grvm_pkg::op_t        din,
	input  logic                 pop,
	output grvm_pkg::op_t        dout,
	output grvm_pkg::fifo_stat_t stat
);
	import grvm_pkg::*;

	op_t                store_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign dout       = store_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW + 1)'(1);
			end
		end
	end

endmodule

>>> hdl/grvm_div.sv
// ----------------------------------------------------------------------------
// grvm_div
// Restoring divider, one quotient bit per cycle, 32 by 25 bits.
// ----------------------------------------------------------------------------
module grvm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [24:0] divisor,
	output logic        done,
	output logic [31:0] quo,
	output logic [24:0] rem
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [24:0] rem_q;
	logic [24:0] dvs_q;
	logic [25:0] sh;
	logic [25:0] diff;
	logic        fits;

	assign sh   = {rem_q, quo_q[31]};
	assign diff = sh - {1'b0, dvs_q};
	assign fits = (sh >= {1'b0, dvs_q});
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? diff[24:0] : sh[24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/grvm_sqrt.sv
// ----------------------------------------------------------------------------
// grvm_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module grvm_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [51:0] radicand,
	output logic        done,
	output logic [25:0] root
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [51:0] src_q;
	logic [27:0] rem_q;
	logic [25:0] root_q;
	logic [27:0] remsh;
	logic [27:0] trial;
	logic        fits;

	assign remsh = {rem_q[25:0], src_q[51:50]};
	assign trial = {root_q, 2'b01};
	assign fits  = (remsh >= trial);
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			src_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			src_q  <= {src_q[49:0], 2'b00};
			rem_q  <= fits ? (remsh - trial) : remsh;
			root_q <= {root_q[24:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd25) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/grvm_back.sv
// ----------------------------------------------------------------------------
// grvm_back
// Executes queued items: map writes, the column march and the distance.
// ----------------------------------------------------------------------------
module grvm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grvm_pkg::op_t        op,
	input  grvm_pkg::fifo_stat_t fifo_stat,
	output logic                 pop,
	input  grvm_pkg::map_cfg_t   map_cfg,
	grvm_result_if.source        result,
	output grvm_pkg::back_stat_t stat
);
	import grvm_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_TW   = 4'd2;
	localparam logic [3:0] S_NW   = 4'd3;
	localparam logic [3:0] S_ADDR = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_DST  = 4'd7;
	localparam logic [3:0] S_DW   = 4'd8;
	localparam logic [3:0] S_SQ   = 4'd9;
	localparam logic [3:0] S_SST  = 4'd10;
	localparam logic [3:0] S_SW   = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0] st_q;
	logic [3:0] st_d;

	// Map storage: one row of cells per word, a valid bit per row.
	logic [MAP_DIM-1:0] mem [MAP_DIM];
	logic [MAP_DIM-1:0] row_vld_q;
	logic [MAP_DIM-1:0] rd_row_q;
	logic               rd_vld_q;
	logic               mem_we;
	logic               mem_re;
	logic [MAP_DIM-1:0] wr_bit;
	logic [MAP_DIM-1:0] wr_mask;
	logic [MAP_DIM-1:0] wr_data;
	logic [MAP_AW-1:0]  rd_addr;

	// Ray state.
	logic [16:0]             ca_q;
	logic [16:0]             sa_q;
	logic                    right_q;
	logic                    down_q;
	logic [13:0]             posy_q;
	logic [8:0]              x0_q;
	logic signed [COL_W-1:0] col_q;
	logic [14:0]             dx_q;
	logic [30:0]             base_q;
	logic [25:0]             xsa_q;
	logic [16:0]             tq_q;
	logic [24:0]             sq_q;
	logic signed [QW-1:0]    q_q;
	logic [24:0]             rem_q;
	logic [31:0]             run_q;
	logic [24:0]             dy_q;
	logic [29:0]             dx2_q;
	logic [49:0]             dy2_q;

	logic        res_valid_q;
	logic        res_hit_q;
	logic [23:0] res_dist_q;
	logic        out_free;
	logic        res_load;
	logic        res_hit;
	logic [23:0] res_dist;

	logic        div_start;
	logic [31:0] div_a;
	logic [24:0] div_b;
	logic        div_done;
	logic [31:0] div_quo;
	logic [24:0] div_rem;
	logic        sq_start;
	logic        sq_done;
	logic [25:0] sq_root;

	logic [24:0] dvs;
	logic [31:0] n0;
	logic        n0_neg;
	logic        col_bad;
	logic        row_bad;
	logic        cell_open;
	logic [25:0] rs_add;
	logic [25:0] rs_sub;
	logic [25:0] dvs_ext;
	logic [QW-1:0] tq_ext;

	grvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	grvm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (52'(dx2_q) + 52'(dy2_q)),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign dvs     = {ca_q, 8'b0};
	assign dvs_ext = {1'b0, dvs};
	assign tq_ext  = QW'(tq_q);
	assign n0      = down_q ? (32'(base_q) + 32'(xsa_q)) : (32'(base_q) - 32'(xsa_q));
	assign n0_neg  = !down_q && (31'(xsa_q) > base_q);
	assign col_bad = col_q[COL_W-1] || (col_q[COL_W-2:0] >= (COL_W - 1)'(map_cfg.cols));
	assign row_bad = q_q[QW-1] || (q_q[QW-2:0] >= (QW - 1)'(map_cfg.rows));
	assign rd_addr = q_q[MAP_AW-1:0];
	assign cell_open = rd_vld_q && rd_row_q[col_q[MAP_AW-1:0]];
	assign rs_add  = {1'b0, rem_q} + {1'b0, sq_q};
	assign rs_sub  = {1'b0, rem_q} - {1'b0, sq_q};

	assign wr_bit  = MAP_DIM'(1) << op.wr_col;
	assign wr_data = op.wr_open ? wr_bit : '0;
	assign wr_mask = row_vld_q[op.wr_row] ? wr_bit : '1;

	assign out_free = !res_valid_q || result.ready;

	always_comb begin
		st_d      = st_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		div_start = 1'b0;
		div_a     = run_q;
		div_b     = 25'(ca_q);
		sq_start  = 1'b0;
		res_load  = 1'b0;
		res_hit   = 1'b1;
		res_dist  = (sq_root > 26'(DIST_MAX)) ? DIST_MAX : sq_root[23:0];
		unique case (st_q)
			S_IDLE: begin
				if (!fifo_stat.empty) begin
					if (op.is_write) begin
						pop    = 1'b1;
						mem_we = op.in_grid;
					end else if (op.cos_zero) begin
						if (out_free) begin
							pop      = 1'b1;
							res_load = 1'b1;
							res_hit  = 1'b0;
							res_dist = '0;
						end
					end else begin
						pop  = 1'b1;
						st_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				div_start = 1'b1;
				div_a     = 32'(sa_q);
				div_b     = 25'(ca_q);
				st_d      = S_TW;
			end
			S_TW: begin
				if (div_done) begin
					if (n0_neg) begin
						st_d = S_ADDR;
					end else begin
						div_start = 1'b1;
						div_a     = n0;
						div_b     = dvs;
						st_d      = S_NW;
					end
				end
			end
			S_NW: begin
				if (div_done) begin
					st_d = S_ADDR;
				end
			end
			S_ADDR: begin
				if (col_bad || row_bad) begin
					st_d = S_FIN;
				end else begin
					mem_re = 1'b1;
					st_d   = S_CHK;
				end
			end
			S_CHK: begin
				st_d = cell_open ? S_ADDR : S_FIN;
			end
			S_FIN: begin
				st_d = S_DST;
			end
			S_DST: begin
				div_start = 1'b1;
				st_d      = S_DW;
			end
			S_DW: begin
				if (div_done) begin
					st_d = S_SQ;
				end
			end
			S_SQ: begin
				st_d = S_SST;
			end
			S_SST: begin
				sq_start = 1'b1;
				st_d     = S_SW;
			end
			S_SW: begin
				if (sq_done) begin
					st_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					res_load = 1'b1;
					st_d     = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	// Map memory, per-bit write mask, registered row read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int b = 0; b < MAP_DIM; b++) begin
				if (wr_mask[b]) begin
					mem[op.wr_row][b] <= wr_data[b];
				end
			end
		end
		if (mem_re) begin
			rd_row_q <= mem[rd_addr];
			rd_vld_q <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				ca_q    <= op.ca;
				sa_q    <= op.sa;
				right_q <= op.right;
				down_q  <= op.down;
				posy_q  <= op.pos_y;
				x0_q    <= op.x0;
				col_q   <= op.col0;
				dx_q    <= 15'(op.x0);
			end
			S_MUL: begin
				base_q <= 31'(posy_q) * 31'(ca_q);
				xsa_q  <= 26'(x0_q) * 26'(sa_q);
			end
			S_TW: begin
				if (div_done) begin
					tq_q <= div_quo[16:0];
					sq_q <= {div_rem[16:0], 8'b0};
					if (n0_neg) begin
						q_q   <= '1;
						rem_q <= '0;
					end
				end
			end
			S_NW: begin
				if (div_done) begin
					q_q   <= QW'(div_quo);
					rem_q <= div_rem;
				end
			end
			S_CHK: begin
				if (cell_open) begin
					dx_q  <= dx_q + 15'd256;
					col_q <= right_q ? (col_q + COL_W'(1)) : (col_q - COL_W'(1));
					if (down_q) begin
						if (rs_add >= dvs_ext) begin
							rem_q <= 25'(rs_add - dvs_ext);
							q_q   <= q_q + tq_ext + QW'(1);
						end else begin
							rem_q <= rs_add[24:0];
							q_q   <= q_q + tq_ext;
						end
					end else begin
						if (rs_sub[25]) begin
							rem_q <= 25'(rs_sub + dvs_ext);
							q_q   <= q_q - tq_ext - QW'(1);
						end else begin
							rem_q <= rs_sub[24:0];
							q_q   <= q_q - tq_ext;
						end
					end
				end
			end
			S_FIN: begin
				run_q <= 32'(dx_q) * 32'(sa_q);
			end
			S_DW: begin
				if (div_done) begin
					dy_q <= div_quo[24:0];
				end
			end
			S_SQ: begin
				dx2_q <= 30'(dx_q) * 30'(dx_q);
				dy2_q <= 50'(dy_q) * 50'(dy_q);
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_hit_q  <= res_hit;
			res_dist_q <= res_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			row_vld_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (mem_we) begin
				row_vld_q[op.wr_row] <= 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid     = res_valid_q;
	assign result.hit_valid = res_hit_q;
	assign result.distance  = res_dist_q;

	assign stat.pop      = pop;
	assign stat.pop_cast = pop && !op.is_write && !op.cos_zero;
	assign stat.busy     = (st_q != S_IDLE);
	assign stat.res_load = res_load;

endmodule

>>> hdl/grid_ray_vertical_march.sv
// ----------------------------------------------------------------------------
// grid_ray_vertical_march
// Grid map with a ray march across vertical cell boundaries.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake     Carries
// cmd       in         valid/ready   kind, cell_row, cell_col, cell_open,
//                                    pos_x, pos_y, angle
// result    out        valid/ready   hit_valid, distance
// cfg       in         valid/ready   index (0 map_rows, 1 map_cols), data
//
// A map write is done in the idle state and gives no result; a cast at a zero
// cosine is answered there too, with a miss and distance zero. Any other cast
// runs the march sequence, whose cost grows with the open columns crossed (at
// most 63). It is set by three passes through the shared divider, or two when
// the first boundary already lies above row zero, by the square root and by
// the map read of each step.
// Reset clears the map's row valid bits at once, so all cells read blocked.
// The front keeps taking items while the back works, until the four-entry
// queue fills; a stalled result holds in the output register.
//
// The front end looks up sine and cosine for each cast and places every item,
// write or cast, into a short queue so that map writes and casts are executed
// in order. The back end marches the ray one column per step: the row is kept
// as a quotient and remainder of the boundary's y numerator by 256 times the
// cosine, advanced by the tangent's integer and fractional parts, so that no
// division is needed inside the march. Once the ray stops, the vertical run is
// divided out and the Euclidean distance is found by an iterative square root.
//
`include "grid_ray_vertical_march_assert.svh"

module grid_ray_vertical_march (
	input logic           clk,
	input logic           arst_n,
	grvm_cmd_if.sink      cmd,
	grvm_result_if.source result,
	grvm_cfg_if.sink      cfg
);
	import grvm_pkg::*;

	logic [CFG_DW-1:0] map_rows_q;
	logic [CFG_DW-1:0] map_cols_q;
	map_cfg_t          map_cfg;
	op_t               op_in;
	op_t               op_head;
	logic              push;
	logic              pop;
	fifo_stat_t        fifo_stat;
	back_stat_t        back_stat;

	// Registers accept a write in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q <= CFG_DW'(64);
			map_cols_q <= CFG_DW'(64);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAP_ROWS: map_rows_q <= cfg.data;
				REG_MAP_COLS: map_cols_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Register values above the grid size act as the grid size.
	always_comb begin
		if (int'(map_rows_q) > MAP_DIM) begin
			map_cfg.rows = DIM_W'(MAP_DIM);
		end else begin
			map_cfg.rows = DIM_W'(map_rows_q);
		end
		if (int'(map_cols_q) > MAP_DIM) begin
			map_cfg.cols = DIM_W'(MAP_DIM);
		end else begin
			map_cfg.cols = DIM_W'(map_cols_q);
		end
	end

	grvm_front u_front (
		.cmd       (cmd),
		.fifo_stat (fifo_stat),
		.push      (push),
		.op        (op_in)
	);

	grvm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (op_in),
		.pop    (pop),
		.dout   (op_head),
		.stat   (fifo_stat)
	);

	grvm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.map_cfg   (map_cfg),
		.result    (result),
		.stat      (back_stat)
	);

	// The back end never pops an empty queue.
	`GRVM_ASSERT(a_pop_not_empty, clk, arst_n, back_stat.pop, !fifo_stat.empty)
	// A result is loaded only into a free or draining output register.
	`GRVM_ASSERT(a_load_free, clk, arst_n, back_stat.res_load, !result.valid || result.ready)
	// Taking a cast with a nonzero cosine starts the march sequence.
	`GRVM_ASSERT_NEXT(a_cast_busy, clk, arst_n, back_stat.pop_cast, back_stat.busy)

endmodule

>>> tb/tb_grid_ray_vertical_march.sv
// ----------------------------------------------------------------------------
// tb_grid_ray_vertical_march
// Self-checking bench for the grid map ray march. A directed table covers
// the extreme fields and the special angles, with hand-computed distances
// where they are obvious. Random phases then build open regions in the map
// and cast rays into them. Each phase uses its own map size setting. Every
// result is compared with a local bit-exact model of the march.
// ----------------------------------------------------------------------------
module tb_grid_ray_vertical_march;
	import grvm_pkg::*;

	// Long enough to cover one full cast in flight.
	localparam int DRAIN_CYCLES = 400;
	localparam int MAX_GAP      = 12;

	typedef struct {
		bit        kind;
		bit [5:0]  row;
		bit [5:0]  col;
		bit        open;
		bit [13:0] px;
		bit [13:0] py;
		bit [11:0] ang;
		bit        typed;
		bit        hv;
		bit [23:0] dist_v;
	} stim_row_t;

	typedef struct {
		logic        hv;
		logic [23:0] dist_v;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	grvm_cmd_if    cmd ();
	grvm_result_if result ();
	grvm_cfg_if    cfg ();

	grid_ray_vertical_march dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	always #5 clk = ~clk;

	// Local copy of the block's state.
	bit         map_open [0:MAP_DIM*MAP_DIM-1];
	logic [6:0] rows_reg;
	logic [6:0] cols_reg;

	hit_t hit_q[$];
	int   mismatches = 0;
	bit   steady = 1'b0;

	// Quarter-turn sine table, Q1.16.
	const longint unsigned SINE_TAB [0:16] = '{
		0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
		50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536
	};

	function automatic longint unsigned quarter_sine(input int unsigned t);
		int unsigned u;
		int unsigned i;
		int unsigned f;
		u = t << (18 - ANGLE_BITS);
		i = u >> 12;
		f = u & 4095;
		if (i >= 16)
			return SINE_TAB[16];
		return SINE_TAB[i] + (((SINE_TAB[i+1] - SINE_TAB[i]) * f) >> 12);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned b;
		rem = n;
		root = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// Marches one ray across the vertical boundaries of the local map.
	function automatic hit_t march_ray(input bit [13:0] px, input bit [13:0] py,
			input bit [11:0] ang);
		hit_t h;
		int unsigned quarter;
		int unsigned qd;
		int unsigned r;
		int unsigned rows_eff;
		int unsigned cols_eff;
		longint unsigned ca;
		longint unsigned sa;
		longint unsigned x0;
		longint unsigned dx;
		longint unsigned run;
		longint unsigned base;
		longint unsigned num;
		longint unsigned row;
		longint unsigned dy;
		longint unsigned d;
		longint col0;
		longint col;
		bit right;
		bit down;
		quarter = 1 << (ANGLE_BITS - 2);
		qd = ang >> (ANGLE_BITS - 2);
		r = ang & (quarter - 1);
		rows_eff = (rows_reg < MAP_DIM) ? rows_reg : MAP_DIM;
		cols_eff = (cols_reg < MAP_DIM) ? cols_reg : MAP_DIM;
		// Straight up or down: the cosine is zero and no boundary is ever met.
		if (qd[0] && r == 0) begin
			h.hv = 1'b0;
			h.dist_v = '0;
			return h;
		end
		if (!qd[0]) begin
			ca = quarter_sine(quarter - r);
			sa = quarter_sine(r);
		end else begin
			ca = quarter_sine(r);
			sa = quarter_sine(quarter - r);
		end
		right = (qd == 0 || qd == 3);
		down = (qd == 2 || qd == 3);
		if (right) begin
			col0 = longint'(px >> 8) + 1;
			x0 = 256 - (px & 255);
		end else begin
			col0 = longint'(px >> 8) - 1;
			x0 = px & 255;
		end
		base = longint'(py) * ca;
		dx = 0;
		run = 0;
		for (int k = 0; k < 2 * MAP_DIM + 130; k++) begin
			col = right ? col0 + k : col0 - k;
			dx = x0 + 256 * longint'(k);
			run = dx * sa;
			if (col < 0 || col >= cols_eff)
				break;
			if (down) begin
				num = base + run;
			end else begin
				// Above row zero is outside the map.
				if (run > base)
					break;
				num = base - run;
			end
			row = num / (256 * ca);
			if (row >= rows_eff)
				break;
			if (!map_open[row * MAP_DIM + col])
				break;
		end
		dy = run / ca;
		d = int_sqrt(dx * dx + dy * dy);
		h.hv = 1'b1;
		h.dist_v = (d > 64'hFFFFFF) ? DIST_MAX : d[23:0];
		return h;
	endfunction

	// Waits out the sender gap, offers one item and books its expectation.
	task automatic send_item(input stim_row_t s);
		int gap;
		hit_t h;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.kind      <= s.kind;
		cmd.cell_row  <= s.row;
		cmd.cell_col  <= s.col;
		cmd.cell_open <= s.open;
		cmd.pos_x     <= s.px;
		cmd.pos_y     <= s.py;
		cmd.angle     <= s.ang;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		if (!s.kind) begin
			map_open[s.row * MAP_DIM + s.col] = s.open;
		end else begin
			h = march_ray(s.px, s.py, s.ang);
			// Table rows with a typed answer are held to it as well.
			if (s.typed && (h.hv !== s.hv || h.dist_v !== s.dist_v)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row: expected %0d/%0d, model gives %0d/%0d",
						s.hv, s.dist_v, h.hv, h.dist_v);
			end
			if (s.typed) begin
				h.hv = s.hv;
				h.dist_v = s.dist_v;
			end
			hit_q.push_back(h);
		end
	endtask

	// Lets every booked result arrive, then the tail of any trailing write.
	task automatic drain_block();
		cmd.valid <= 1'b0;
		while (hit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [6:0] val);
		drain_block();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == REG_MAP_ROWS)
			rows_reg = val;
		else
			rows_reg = rows_reg;
		if (idx == REG_MAP_COLS)
			cols_reg = val;
	endtask

	// Result side: random stall per item, then compare with the oldest booking.
	int stall_left = 0;
	always @(posedge clk) begin
		hit_t e;
		if (arst_n && result.valid && result.ready) begin
			if (hit_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: %0d/%0d",
						result.hit_valid, result.distance);
			end else begin
				e = hit_q.pop_front();
				if (result.hit_valid !== e.hv || result.distance !== e.dist_v) begin
					mismatches++;
					if (mismatches <= 10)
						$display("hit mismatch: expected %0d/%0d, got %0d/%0d",
							e.hv, e.dist_v, result.hit_valid, result.distance);
				end
			end
			stall_left = steady ? 0 : $urandom_range(0, MAX_GAP);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		result.ready <= (stall_left == 0);
	end

	// Draws a random item; casts mostly start inside the map in use.
	function automatic stim_row_t random_item(input int cast_pct, input int open_pct);
		stim_row_t s;
		int unsigned rl;
		int unsigned cl;
		rl = (rows_reg == 0) ? 1 : ((rows_reg > MAP_DIM) ? MAP_DIM : rows_reg);
		cl = (cols_reg == 0) ? 1 : ((cols_reg > MAP_DIM) ? MAP_DIM : cols_reg);
		s = '{default: 0};
		s.kind = ($urandom_range(0, 99) < cast_pct);
		s.row = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, rl - 1));
		s.col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, cl - 1));
		s.open = ($urandom_range(0, 99) < open_pct);
		if ($urandom_range(0, 9) == 0) begin
			s.px = 14'($urandom_range(0, 16383));
			s.py = 14'($urandom_range(0, 16383));
		end else begin
			s.px = 14'($urandom_range(0, cl * 256 - 1));
			s.py = 14'($urandom_range(0, rl * 256 - 1));
		end
		case ($urandom_range(0, 7))
			0: s.ang = 12'($urandom_range(0, 3) * 1024);
			1: s.ang = 12'($urandom_range(0, 3) * 1024 + $urandom_range(0, 2) - 1);
			default: s.ang = 12'($urandom_range(0, 4095));
		endcase
		return s;
	endfunction

	// Directed table; the hand-computed rows come right after reset, when every
	// cell is blocked, and from a short corridor in row zero.
	stim_row_t table_rows [] = '{
		'{1, 0, 0, 0, 14'h0180, 14'h0180, 12'd0,    1, 1, 24'd128},
		'{1, 0, 0, 0, 14'h0180, 14'h0180, 12'd1024, 1, 0, 24'd0},
		'{1, 0, 0, 0, 14'h0180, 14'h0180, 12'd3072, 1, 0, 24'd0},
		'{1, 0, 0, 0, 14'h0180, 14'h0180, 12'd2048, 1, 1, 24'd128},
		'{1, 0, 0, 0, 14'h3FFF, 14'h3FFF, 12'd0,    1, 1, 24'd1},
		'{1, 0, 0, 0, 14'h0000, 14'h0000, 12'd0,    1, 1, 24'd256},
		'{0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
		'{0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
		'{0, 0, 2, 1, 0, 0, 0, 0, 0, 0},
		'{0, 63, 63, 0, 0, 0, 0, 0, 0, 0},
		'{0, 63, 63, 1, 0, 0, 0, 0, 0, 0},
		'{0, 1, 1, 1, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 14'h0080, 14'h0080, 12'd0,    1, 1, 24'd640},
		'{1, 0, 0, 0, 14'h0280, 14'h0080, 12'd2048, 1, 1, 24'd640},
		'{1, 0, 0, 0, 14'h0080, 14'h0080, 12'd4095, 0, 0, 0},
		'{1, 0, 0, 0, 14'h0080, 14'h0080, 12'd1,    0, 0, 0},
		'{1, 0, 0, 0, 14'h0080, 14'h0180, 12'd1023, 0, 0, 0},
		'{1, 0, 0, 0, 14'h0280, 14'h0080, 12'd1025, 0, 0, 0},
		'{1, 0, 0, 0, 14'h0280, 14'h0080, 12'd3071, 0, 0, 0},
		'{1, 0, 0, 0, 14'h0080, 14'h0080, 12'd3073, 0, 0, 0},
		'{1, 0, 0, 0, 14'h3F80, 14'h3F80, 12'd2560, 0, 0, 0},
		'{1, 0, 0, 0, 14'h0000, 14'h0000, 12'd512,  0, 0, 0}
	};

	// Map size settings per random phase: defaults, the smallest, above the
	// grid, zero, and a few uneven shapes.
	int phase_rows [7] = '{64, 1, 127, 0, 20, 64, 9};
	int phase_cols [7] = '{64, 1, 127, 0, 37, 5, 64};

	initial begin
		cmd.valid = 1'b0;
		cmd.kind = 1'b0;
		cmd.cell_row = '0;
		cmd.cell_col = '0;
		cmd.cell_open = 1'b0;
		cmd.pos_x = '0;
		cmd.pos_y = '0;
		cmd.angle = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		result.ready = 1'b0;
		foreach (map_open[i])
			map_open[i] = 1'b0;
		rows_reg = 7'd64;
		cols_reg = 7'd64;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_item(table_rows[i]);

		for (int p = 0; p < 7; p++) begin
			write_reg(REG_MAP_ROWS, 7'(phase_rows[p]));
			write_reg(REG_MAP_COLS, 7'(phase_cols[p]));
			// Some phases run with no idling on either side.
			steady = (p == 2 || p == 5);
			// Open up a good part of the area in use, then mix writes and casts.
			for (int n = 0; n < 70; n++)
				send_item(random_item(0, 80));
			for (int n = 0; n < 150; n++)
				send_item(random_item(70, 70));
			steady = 1'b0;
		end

		drain_block();
		if (mismatches == 0)
			$display("tb_grid_ray_vertical_march OK");
		else
			$display("tb_grid_ray_vertical_march NOT OK");
		$finish;
	end

	initial begin
		#40000000;
		$display("tb_grid_ray_vertical_march NOT OK");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/grvm_pkg.sv
hdl/grvm_ifs.sv
hdl/grvm_front.sv
hdl/grvm_fifo.sv
hdl/grvm_div.sv
hdl/grvm_sqrt.sv
hdl/grvm_back.sv
hdl/grid_ray_vertical_march.sv
tb/tb_grid_ray_vertical_march.sv
